// ----- sv/tetrahedron_circumsphere_top_defines.svh -----
// Assertion macros for the circumsphere block
`ifndef TETRAHEDRON_CIRCUMSPHERE_TOP_DEFINES_SVH
`define TETRAHEDRON_CIRCUMSPHERE_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define TCS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TCS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tcs_pkg.sv -----
// Shared constants for the tetrahedron circumsphere block
`default_nettype none
package tcs_pkg;
	localparam int TCS_COORD_WIDTH = 32;
	localparam int TCS_FRAC_BITS   = 16;
	localparam int TCS_MUL_DIGIT   = 16;
	localparam int TCS_PADDR_W     = 3;
	localparam logic TCS_REG_DET_THR = 1'b0;
endpackage
`default_nettype wire

// ----- sv/tcs_vtx_if.sv -----
// Vertex channel: four vertices of one tetrahedron per beat
`default_nettype none
interface tcs_vtx_if #(parameter int W = tcs_pkg::TCS_COORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [W-1:0] p0_x, p0_y, p0_z;
	logic signed [W-1:0] p1_x, p1_y, p1_z;
	logic signed [W-1:0] p2_x, p2_y, p2_z;
	logic signed [W-1:0] p3_x, p3_y, p3_z;
	modport source(output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
	modport sink(input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface
`default_nettype wire

// ----- sv/tcs_sph_if.sv -----
// Sphere channel: centre, radius and degenerate flag per beat
`default_nettype none
interface tcs_sph_if #(parameter int W = tcs_pkg::TCS_COORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [W-1:0] center_x, center_y, center_z;
	logic [W-1:0] radius;
	logic degenerate;
	modport source(output valid, center_x, center_y, center_z, radius, degenerate,
		input ready);
	modport sink(input valid, center_x, center_y, center_z, radius, degenerate,
		output ready);
endinterface
`default_nettype wire

// ----- sv/tcs_mul.sv -----
// Pipelined signed multiplier, one digit of b per stage
`default_nettype none
module tcs_mul #(
	parameter int AW  = 33,
	parameter int BW  = 33,
	parameter int DIG = tcs_pkg::TCS_MUL_DIGIT
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AW-1:0]   a,
	input  logic signed [BW-1:0]   b,
	output logic signed [AW+BW-1:0] p
);
	localparam int NDIG = (BW + DIG - 1) / DIG;
	localparam int BX   = NDIG * DIG;
	localparam int PW   = AW + BW;

	logic signed [AW-1:0] a_s   [NDIG];
	logic [BX-1:0]        b_s   [NDIG];
	logic signed [PW-1:0] acc_s [NDIG];

	for (genvar k = 0; k < NDIG; k++) begin : g_dig
		logic signed [AW-1:0]    a_in;
		logic [BX-1:0]           b_in;
		logic signed [PW-1:0]    acc_in;
		logic signed [DIG:0]     dg;
		logic signed [AW+DIG:0]  pp;

		if (k == 0) begin : g_first
			logic signed [BX-1:0] bx;
			assign bx     = BX'(b);
			assign a_in   = a;
			assign b_in   = bx;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_s[k-1];
			assign b_in   = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		// top digit carries the sign
		if (k == NDIG - 1) begin : g_top
			assign dg = {b_in[k*DIG+DIG-1], b_in[k*DIG +: DIG]};
		end else begin : g_low
			assign dg = {1'b0, b_in[k*DIG +: DIG]};
		end

		assign pp = a_in * dg;

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]   <= a_in;
				b_s[k]   <= b_in;
				acc_s[k] <= acc_in + (PW'(pp) <<< (k * DIG));
			end
		end
	end

	assign p = acc_s[NDIG-1];
endmodule
`default_nettype wire

// ----- sv/tcs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tcs_div #(
	parameter int NW = 64,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic [QW-1:0] q
);
	localparam int XW = NW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [NW-1:0] den_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int BI = QW - 1 - j;
		logic [NW-1:0] rem_in, den_in;
		logic [QW-1:0] q_in;
		logic [XW-1:0] dsh;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign q_in   = q_s[j-1];
		end

		assign dsh = XW'(den_in) << BI;
		assign ge  = XW'(rem_in) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? (rem_in - NW'(dsh)) : rem_in;
				den_s[j] <= den_in;
				q_s[j]   <= ge ? (q_in | (QW'(1) << BI)) : q_in;
			end
		end
	end

	assign q = q_s[QW-1];
endmodule
`default_nettype wire

// ----- sv/tetrahedron_circumsphere_top.sv -----
// Tetrahedron circumsphere: exact Cramer solve, rounding, saturation, integer sqrt
//
//  channel  dir  handshake          payload
//  tet      in   valid/ready        p0_x .. p3_z, signed Q16.16
//  sph      out  valid/ready        center_x/y/z, radius, degenerate
//  apb      in   psel/penable       det_threshold at byte address 0
//
// One beat enters per cycle while tet.ready is high. For COORD_WIDTH 32 a taken beat passes the
// input register, 3+5+3 multiplier digits, 32 divider and 33 root stages, adders, output reg.
// arst_n clears valid bits, the output and skid valid flags and det_threshold.
// A stalled output fills one skid register; only then does tet.ready fall and
// the whole pipeline freeze.
`default_nettype none
module tetrahedron_circumsphere_top #(
	parameter int COORD_WIDTH = tcs_pkg::TCS_COORD_WIDTH,
	parameter int FRAC_BITS   = tcs_pkg::TCS_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tcs_vtx_if.sink                         tet,
	tcs_sph_if.source                       sph,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcs_pkg::TCS_PADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import tcs_pkg::*;
	`include "tetrahedron_circumsphere_top_defines.svh"

	localparam int W    = COORD_WIDTH;
	localparam int MD   = TCS_MUL_DIGIT;
	localparam int EW   = W + 1;
	localparam int P1W  = 2 * EW;
	localparam int CRW  = P1W + 1;
	localparam int BW   = P1W + 2;
	localparam int P2W  = BW + CRW;
	localparam int DW   = P2W + 2;
	localparam int NUMW = DW + 1;
	localparam int SQW  = P1W + 2;
	localparam int RW   = W + 1;

	localparam int LA = (EW + MD - 1) / MD;
	localparam int LB = (CRW + MD - 1) / MD;

	localparam int L_IN   = 1;
	localparam int L_A    = L_IN + LA;
	localparam int L_ADD1 = L_A + 1;
	localparam int L_B    = L_ADD1 + LB;
	localparam int L_ADD2 = L_B + 1;
	localparam int L_X1   = L_ADD2 + 1;
	localparam int L_X2   = L_X1 + 1;
	localparam int L_DIV  = L_X2 + W;
	localparam int L_CEN  = L_DIV + 1;
	localparam int L_DIFF = L_CEN + 1;
	localparam int L_SQ   = L_DIFF + LA;
	localparam int L_SUM  = L_SQ + 1;
	localparam int L_RT   = L_SUM + RW;

	typedef struct packed {
		logic signed [W-1:0] cx;
		logic signed [W-1:0] cy;
		logic signed [W-1:0] cz;
		logic [W-1:0]        rad;
		logic                dg;
	} res_t;

	// ---------------- configuration ----------------
	logic [31:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == TCS_REG_DET_THR) begin
			thr_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == TCS_REG_DET_THR) ? thr_q : '0;

	// ---------------- flow control ----------------
	logic en;
	logic skid_v_q, out_v_q;
	logic vld_q [L_IN:L_RT];

	assign en        = !skid_v_q;
	assign tet.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = L_IN; i <= L_RT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[L_IN] <= tet.valid;
			for (int i = L_IN + 1; i <= L_RT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// ---------------- edge vectors ----------------
	logic signed [W-1:0]  pin  [4][3];
	logic signed [EW-1:0] e_s1 [3][3];
	logic signed [EW-1:0] s_s1 [3][3];
	logic signed [EW-1:0] e0_s [L_IN:L_ADD1][3];
	logic signed [W-1:0]  p0_s [L_IN:L_CEN][3];

	assign pin[0][0] = tet.p0_x;
	assign pin[0][1] = tet.p0_y;
	assign pin[0][2] = tet.p0_z;
	assign pin[1][0] = tet.p1_x;
	assign pin[1][1] = tet.p1_y;
	assign pin[1][2] = tet.p1_z;
	assign pin[2][0] = tet.p2_x;
	assign pin[2][1] = tet.p2_y;
	assign pin[2][2] = tet.p2_z;
	assign pin[3][0] = tet.p3_x;
	assign pin[3][1] = tet.p3_y;
	assign pin[3][2] = tet.p3_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[i][k] <= EW'(pin[i+1][k]) - EW'(pin[0][k]);
					s_s1[i][k] <= EW'(pin[i+1][k]) + EW'(pin[0][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				e0_s[L_IN][k] <= EW'(pin[1][k]) - EW'(pin[0][k]);
				p0_s[L_IN][k] <= pin[0][k];
			end
			for (int i = L_IN + 1; i <= L_ADD1; i++) e0_s[i] <= e0_s[i-1];
			for (int i = L_IN + 1; i <= L_CEN; i++) p0_s[i] <= p0_s[i-1];
		end
	end

	// ---------------- cofactors and right-hand side ----------------
	logic signed [P1W-1:0] pa [3][3];
	logic signed [P1W-1:0] pb [3][3];
	logic signed [P1W-1:0] ps [3][3];

	for (genvar i = 0; i < 3; i++) begin : g_ra
		for (genvar k = 0; k < 3; k++) begin : g_ca
			tcs_mul #(.AW(EW), .BW(EW), .DIG(MD)) u_pa (
				.clk(clk), .en(en),
				.a(e_s1[(i+1)%3][(k+1)%3]), .b(e_s1[(i+2)%3][(k+2)%3]),
				.p(pa[i][k]));
			tcs_mul #(.AW(EW), .BW(EW), .DIG(MD)) u_pb (
				.clk(clk), .en(en),
				.a(e_s1[(i+1)%3][(k+2)%3]), .b(e_s1[(i+2)%3][(k+1)%3]),
				.p(pb[i][k]));
			tcs_mul #(.AW(EW), .BW(EW), .DIG(MD)) u_ps (
				.clk(clk), .en(en),
				.a(s_s1[i][k]), .b(e_s1[i][k]),
				.p(ps[i][k]));
		end
	end

	logic signed [CRW-1:0] cr_s [3][3];
	logic signed [BW-1:0]  bv_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) cr_s[i][k] <= CRW'(pa[i][k]) - CRW'(pb[i][k]);
				bv_s[i] <= BW'(ps[i][0]) + BW'(ps[i][1]) + BW'(ps[i][2]);
			end
		end
	end

	// ---------------- determinant and numerators ----------------
	logic signed [P2W-1:0] dm [3];
	logic signed [P2W-1:0] nm [3][3];

	for (genvar k = 0; k < 3; k++) begin : g_det
		tcs_mul #(.AW(BW), .BW(CRW), .DIG(MD)) u_dm (
			.clk(clk), .en(en),
			.a(BW'(e0_s[L_ADD1][k])), .b(cr_s[0][k]),
			.p(dm[k]));
		for (genvar i = 0; i < 3; i++) begin : g_num
			tcs_mul #(.AW(BW), .BW(CRW), .DIG(MD)) u_nm (
				.clk(clk), .en(en),
				.a(bv_s[i]), .b(cr_s[i][k]),
				.p(nm[i][k]));
		end
	end

	logic signed [DW-1:0] d_s;
	logic signed [DW-1:0] n_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= DW'(dm[0]) + DW'(dm[1]) + DW'(dm[2]);
			for (int k = 0; k < 3; k++) n_s[k] <= DW'(nm[0][k]) + DW'(nm[1][k]) + DW'(nm[2][k]);
		end
	end

	// ---------------- magnitudes, threshold, divider operands ----------------
	logic [DW-1:0]   md_s;
	logic [DW-1:0]   mn_s  [3];
	logic [NUMW-1:0] num_s [3];
	logic [NUMW-1:0] den_s;
	logic            neg_s   [L_X1:L_DIV][3];
	logic            ovf_s   [L_X2+1:L_DIV][3];
	logic            degen_s [L_X2:L_RT];

	always_ff @(posedge clk) begin
		if (en) begin
			md_s <= d_s[DW-1] ? (~d_s + 1'b1) : d_s;
			for (int k = 0; k < 3; k++) begin
				mn_s[k]        <= n_s[k][DW-1] ? (~n_s[k] + 1'b1) : n_s[k];
				neg_s[L_X1][k] <= n_s[k][DW-1] ^ d_s[DW-1];
			end
			for (int i = L_X1 + 1; i <= L_DIV; i++) neg_s[i] <= neg_s[i-1];

			for (int k = 0; k < 3; k++) num_s[k] <= NUMW'(md_s) + NUMW'(mn_s[k]);
			den_s            <= {md_s, 1'b0};
			degen_s[L_X2]    <= (md_s >> (2 * FRAC_BITS)) <= DW'(thr_q);
			for (int i = L_X2 + 1; i <= L_RT; i++) degen_s[i] <= degen_s[i-1];

			// quotient would need more than W bits
			for (int k = 0; k < 3; k++) ovf_s[L_X2+1][k] <= (num_s[k] >> W) >= den_s;
			for (int i = L_X2 + 2; i <= L_DIV; i++) ovf_s[i] <= ovf_s[i-1];
		end
	end

	logic [W-1:0] q [3];

	for (genvar k = 0; k < 3; k++) begin : g_div
		tcs_div #(.NW(NUMW), .QW(W)) u_div (
			.clk(clk), .en(en), .num(num_s[k]), .den(den_s), .q(q[k]));
	end

	// ---------------- centre: saturate and sign ----------------
	logic [W-1:0]         lim  [3];
	logic [W-1:0]         vmag [3];
	logic                 negf [3];
	logic signed [W-1:0]  cen_s [L_CEN:L_RT][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lim[k]  = neg_s[L_DIV][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			vmag[k] = (ovf_s[L_DIV][k] || q[k] > lim[k]) ? lim[k] : q[k];
			negf[k] = neg_s[L_DIV][k] && (ovf_s[L_DIV][k] || q[k] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) cen_s[L_CEN][k] <= negf[k] ? (~vmag[k] + 1'b1) : vmag[k];
			for (int i = L_CEN + 1; i <= L_RT; i++) cen_s[i] <= cen_s[i-1];
		end
	end

	// ---------------- squared radius ----------------
	logic signed [EW-1:0]  df_s [3];
	logic signed [P1W-1:0] sqm  [3];
	logic [SQW-1:0]        sq_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) df_s[k] <= EW'(cen_s[L_CEN][k]) - EW'(p0_s[L_CEN][k]);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_sq
		tcs_mul #(.AW(EW), .BW(EW), .DIG(MD)) u_sq (
			.clk(clk), .en(en), .a(df_s[k]), .b(df_s[k]), .p(sqm[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s <= SQW'(sqm[0]) + SQW'(sqm[1]) + SQW'(sqm[2]);
		end
	end

	// ---------------- integer square root, one bit per stage ----------------
	logic [SQW-1:0] rem_s [RW];
	logic [RW-1:0]  rt_s  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_rt
		localparam int BI = RW - 1 - j;
		logic [SQW-1:0] rem_in, trial;
		logic [RW-1:0]  rt_in;

		if (j == 0) begin : g_first
			assign rem_in = sq_s;
			assign rt_in  = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign rt_in  = rt_s[j-1];
		end

		assign trial = (SQW'(rt_in) << (BI + 1)) + (SQW'(1) << (2 * BI));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[j] <= rem_in - trial;
					rt_s[j]  <= rt_in | (RW'(1) << BI);
				end else begin
					rem_s[j] <= rem_in;
					rt_s[j]  <= rt_in;
				end
			end
		end
	end

	// ---------------- result, output register and skid ----------------
	res_t fin, out_q, skid_q;
	logic take;

	always_comb begin
		fin.dg = degen_s[L_RT];
		if (degen_s[L_RT]) begin
			fin.cx  = '0;
			fin.cy  = '0;
			fin.cz  = '0;
			fin.rad = '0;
		end else begin
			fin.cx  = cen_s[L_RT][0];
			fin.cy  = cen_s[L_RT][1];
			fin.cz  = cen_s[L_RT][2];
			fin.rad = rt_s[RW-1][RW-1] ? {W{1'b1}} : rt_s[RW-1][W-1:0];
		end
	end

	assign take = !out_v_q || sph.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			out_v_q  <= skid_v_q || vld_q[L_RT];
			skid_v_q <= 1'b0;
		end else if (vld_q[L_RT] && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (!skid_v_q) begin
			skid_q <= fin;
		end
	end

	assign sph.valid      = out_v_q;
	assign sph.center_x   = out_q.cx;
	assign sph.center_y   = out_q.cy;
	assign sph.center_z   = out_q.cz;
	assign sph.radius     = out_q.rad;
	assign sph.degenerate = out_q.dg;

	`TCS_CHECK(a_skid_behind_out, skid_v_q |-> out_v_q, "skid full with empty output register")
	`TCS_CHECK(a_degen_zero, sph.valid && sph.degenerate |-> sph.radius == '0 && sph.center_x == '0 && sph.center_y == '0 && sph.center_z == '0, "degenerate beat with non-zero payload")
	`TCS_CHECK_NEXT(a_freeze, !en, $stable(vld_q[L_RT]), "pipeline moved while frozen")
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for tetrahedron_circumsphere_top: random and directed tetrahedra, scoreboard check
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tcs_pkg::*;

	localparam int W = TCS_COORD_WIDTH;
	localparam int DRAIN = 120;

	typedef struct {
		logic signed [W-1:0] c[12];
	} tet_t;

	typedef struct {
		logic signed [W-1:0] x, y, z;
		logic [W-1:0] r;
		logic deg;
	} sphere_t;

	class sphere_board;
		typedef logic signed [255:0] acc_t;
		sphere_t spheres[$];
		logic [31:0] thr;
		int errors, n_in, n_out, n_deg, n_sat;

		function new();
			thr = '0;
		endfunction

		function void note_tet(tet_t t);
			acc_t p[4][3], e[3][3], b[3], cr[3][3], d, md, n, cen[3], sq, df;
			logic [255:0] num, den, q, lim, v, rt, bt;
			logic neg;
			int a, c;
			sphere_t s;
			n_in++;
			for (int i = 0; i < 4; i++)
				for (int k = 0; k < 3; k++)
					p[i][k] = t.c[i*3+k];
			for (int i = 0; i < 3; i++) begin
				b[i] = '0;
				for (int k = 0; k < 3; k++) begin
					e[i][k] = p[i+1][k] - p[0][k];
					b[i] = b[i] + (p[i+1][k] + p[0][k]) * e[i][k];
				end
			end
			for (int i = 0; i < 3; i++) begin
				a = (i + 1) % 3;
				c = (i + 2) % 3;
				for (int k = 0; k < 3; k++)
					cr[i][k] = e[a][(k+1)%3] * e[c][(k+2)%3] - e[a][(k+2)%3] * e[c][(k+1)%3];
			end
			d = '0;
			for (int k = 0; k < 3; k++)
				d = d + e[0][k] * cr[0][k];
			md = d[255] ? -d : d;
			if ((256'(md) >> (2 * TCS_FRAC_BITS)) <= 256'(thr)) begin
				s.x = '0; s.y = '0; s.z = '0; s.r = '0; s.deg = 1'b1;
				n_deg++;
				spheres.push_back(s);
				return;
			end
			for (int k = 0; k < 3; k++) begin
				n = '0;
				for (int i = 0; i < 3; i++)
					n = n + b[i] * cr[i][k];
				neg = n[255] != d[255];
				num = 256'(n[255] ? -n : n) + 256'(md);
				den = 256'(md) + 256'(md);
				q = num / den;
				if (q == 0)
					neg = 1'b0;
				lim = neg ? (256'(1) << (W - 1)) : (256'(1) << (W - 1)) - 1;
				if (q > lim) begin
					v = lim;
					n_sat++;
				end else begin
					v = q;
				end
				cen[k] = neg ? -acc_t'(v) : acc_t'(v);
			end
			s.x = cen[0][W-1:0];
			s.y = cen[1][W-1:0];
			s.z = cen[2][W-1:0];
			sq = '0;
			for (int k = 0; k < 3; k++) begin
				df = cen[k] - p[0][k];
				sq = sq + df * df;
			end
			// bitwise integer square root
			num = sq;
			rt = '0;
			bt = 256'(1) << 254;
			while (bt > num)
				bt = bt >> 2;
			while (bt != 0) begin
				if (num >= rt + bt) begin
					num = num - (rt + bt);
					rt = (rt >> 1) + bt;
				end else begin
					rt = rt >> 1;
				end
				bt = bt >> 2;
			end
			s.r = (rt > {W{1'b1}}) ? {W{1'b1}} : rt[W-1:0];
			s.deg = 1'b0;
			spheres.push_back(s);
		endfunction

		function void check_sphere(sphere_t g);
			sphere_t x;
			n_out++;
			if (spheres.size() == 0) begin
				$display("%0t: unexpected sphere beat x=%0d y=%0d z=%0d r=%0d deg=%0b",
					$time, g.x, g.y, g.z, g.r, g.deg);
				errors++;
				return;
			end
			x = spheres.pop_front();
			if (g.x !== x.x) begin
				$display("%0t: center_x exp %0d got %0d", $time, x.x, g.x);
				errors++;
			end
			if (g.y !== x.y) begin
				$display("%0t: center_y exp %0d got %0d", $time, x.y, g.y);
				errors++;
			end
			if (g.z !== x.z) begin
				$display("%0t: center_z exp %0d got %0d", $time, x.z, g.z);
				errors++;
			end
			if (g.r !== x.r) begin
				$display("%0t: radius exp %0d got %0d", $time, x.r, g.r);
				errors++;
			end
			if (g.deg !== x.deg) begin
				$display("%0t: degenerate exp %0b got %0b", $time, x.deg, g.deg);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [TCS_PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int tx_max, rx_max;

	tcs_vtx_if tet_if();
	tcs_sph_if sph_if();
	sphere_board board;

	tetrahedron_circumsphere_top i_dut (
		.clk(clk), .arst_n(arst_n), .tet(tet_if), .sph(sph_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL tetrahedron_circumsphere_top");
		$finish;
	end

	// input and output monitors
	always @(posedge clk) begin
		tet_t t;
		sphere_t g;
		if (arst_n && tet_if.valid && tet_if.ready) begin
			t.c = '{tet_if.p0_x, tet_if.p0_y, tet_if.p0_z, tet_if.p1_x, tet_if.p1_y,
				tet_if.p1_z, tet_if.p2_x, tet_if.p2_y, tet_if.p2_z, tet_if.p3_x,
				tet_if.p3_y, tet_if.p3_z};
			board.note_tet(t);
		end
		if (arst_n && sph_if.valid && sph_if.ready) begin
			g.x = sph_if.center_x;
			g.y = sph_if.center_y;
			g.z = sph_if.center_z;
			g.r = sph_if.radius;
			g.deg = sph_if.degenerate;
			board.check_sphere(g);
		end
	end

	// sphere receiver, with one long hold-off to back the pipeline up
	initial begin
		int g, beats;
		beats = 0;
		sph_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (beats == 150) begin
				sph_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				g = $urandom_range(0, rx_max);
				if (g > 0) begin
					sph_if.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			sph_if.ready <= 1'b1;
			do @(posedge clk); while (!sph_if.valid);
			beats++;
		end
	end

	task automatic apb_write(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {TCS_REG_DET_THR, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.thr = v;
	endtask

	task automatic send_tet(input tet_t t);
		int g;
		tet_if.valid <= 1'b1;
		{tet_if.p0_x, tet_if.p0_y, tet_if.p0_z} <= {t.c[0], t.c[1], t.c[2]};
		{tet_if.p1_x, tet_if.p1_y, tet_if.p1_z} <= {t.c[3], t.c[4], t.c[5]};
		{tet_if.p2_x, tet_if.p2_y, tet_if.p2_z} <= {t.c[6], t.c[7], t.c[8]};
		{tet_if.p3_x, tet_if.p3_y, tet_if.p3_z} <= {t.c[9], t.c[10], t.c[11]};
		do @(posedge clk); while (!tet_if.ready);
		g = $urandom_range(0, tx_max);
		if (g > 0) begin
			tet_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic tet_t random_tet();
		tet_t t;
		int m, base[3];
		logic signed [W-1:0] ext[5];
		ext = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1};
		m = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++)
			base[k] = $urandom_range(0, 1 << 29) - (1 << 28);
		for (int i = 0; i < 12; i++) begin
			if (m < 15)
				t.c[i] = $urandom;
			else if (m < 22)
				t.c[i] = ext[$urandom_range(0, 4)];
			else
				t.c[i] = base[i % 3] + $urandom_range(0, 1 << 22) - (1 << 21);
		end
		// flat and nearly flat tetrahedra
		if (m >= 80) begin
			for (int k = 0; k < 3; k++)
				t.c[9+k] = t.c[3+k] + t.c[6+k] - t.c[k];
			if (m >= 90)
				t.c[11] = t.c[11] + $urandom_range(1, 16);
		end
		return t;
	endfunction

	initial begin
		tet_t t;
		tet_t dir[$];
		logic [31:0] thr_set[5];
		int U;
		U = 1 << TCS_FRAC_BITS;
		board = new();
		tx_max = 10;
		rx_max = 10;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		tet_if.valid = 1'b0;
		{tet_if.p0_x, tet_if.p0_y, tet_if.p0_z, tet_if.p1_x, tet_if.p1_y, tet_if.p1_z,
			tet_if.p2_x, tet_if.p2_y, tet_if.p2_z, tet_if.p3_x, tet_if.p3_y,
			tet_if.p3_z} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		t.c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; dir.push_back(t);
		t.c = '{0, 0, 0, U, 0, 0, 0, U, 0, 0, 0, U}; dir.push_back(t);
		t.c = '{0, 0, 0, 0, U, 0, U, 0, 0, 0, 0, U}; dir.push_back(t);
		t.c = '{0, 0, 0, U, 0, 0, 0, U, 0, U, U, 0}; dir.push_back(t);
		t.c = '{0, 0, 0, U, 0, 0, 0, U, 0, U, U, 1}; dir.push_back(t);
		t.c = '{0, 0, 0, U, 0, 0, 0, U, 0, U, U, -1}; dir.push_back(t);
		t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}; dir.push_back(t);
		t.c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
		dir.push_back(t);
		t.c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
		dir.push_back(t);
		t.c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		dir.push_back(t);
		for (int i = 0; i < 12; i++) t.c[i] = 32'sh7FFFFFFF;
		dir.push_back(t);
		for (int i = 0; i < 12; i++) t.c[i] = -1;
		dir.push_back(t);
		t.c = '{-U, -U, -U, U, -U, U, -U, U, U, U, U, -U}; dir.push_back(t);
		t.c = '{100*U, 100*U, 100*U, 100*U+1, 100*U, 100*U, 100*U, 100*U+1, 100*U,
			100*U, 100*U, 100*U+1};
		dir.push_back(t);
		foreach (dir[i]) send_tet(dir[i]);
		tet_if.valid <= 1'b0;

		thr_set = '{32'd0, 32'hFFFFFFFF, 32'd1, $urandom, 32'd100};
		for (int ph = 0; ph < 5; ph++) begin
			while (board.spheres.size() != 0) @(posedge clk);
			repeat (DRAIN) @(posedge clk);
			apb_write(thr_set[ph]);
			tx_max = (ph == 1 || ph == 3) ? 0 : 10;
			rx_max = (ph == 3) ? 0 : 10;
			for (int n = 0; n < 128; n++) send_tet(random_tet());
			tet_if.valid <= 1'b0;
		end

		while (board.spheres.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Run: %0d tetrahedra in, %0d spheres out, %0d degenerate, %0d centre coords saturated",
			board.n_in, board.n_out, board.n_deg, board.n_sat);
		$display("Five threshold settings including 0 and all ones; %0d mismatches", board.errors);
		if (board.errors == 0)
			$display("PASS tetrahedron_circumsphere_top");
		else
			$display("FAIL tetrahedron_circumsphere_top");
		$finish;
	end
endmodule
`default_nettype wire
